// ===== hw/rtl/segment_intersection_test_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection test
// Shared property forms, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Same-cycle implication
`define SIT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segment_intersection_test: same-cycle check failed");

// Next-cycle implication
`define SIT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segment_intersection_test: next-cycle check failed");

`endif

// ===== hw/rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared constants for the segment pair hit test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

   // Default coordinate width
   localparam int COORD_BITS_DEFAULT = 16;

   // Number of coordinate fields in one request transaction
   localparam int NUM_COORDS = 8;

   // Result stream width: hit flag padded to one byte
   localparam int RSP_TDATA_BITS = 8;

endpackage

`default_nettype wire

// ===== hw/rtl/segment_intersection_test.sv =====
// An accepted request transaction is registered in stages 1, 2, 3 and 4 in turn;
//   stage 4 drives rsp_tvalid. Throughput: one segment pair per cycle while rsp_tready
//   holds, set by the four-stage multiplier pipeline; each stage advances when it is empty or its successor moves.
// A stalled result holds in the output stage while earlier stages keep filling.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// Segment intersection test
// Streams pairs of 2D segments and returns a hit flag for each pair, using
// exact cross-multiplied slope tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_intersection_test_defines.svh"

module segment_intersection_test #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // fields, low bit up: a_start_x, a_start_y, a_end_x, a_end_y,
   //                     b_start_x, b_start_y, b_end_x, b_end_y
   input  wire logic [sit_pkg::NUM_COORDS*COORD_BITS-1:0] req_tdata,
   // result stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // fields, low bit up: hit, then zero padding
   output logic [sit_pkg::RSP_TDATA_BITS-1:0]         rsp_tdata
);

   import sit_pkg::*;

   localparam int W = COORD_BITS;       // coordinate
   localparam int D = W + 1;            // coordinate difference
   localparam int P = 2 * W + 2;        // product of two differences
   localparam int S = 2 * W + 3;        // difference of two products

   // ------------------------------------------------------------------
   // Unpack request fields
   // ------------------------------------------------------------------
   logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   assign x1 = req_tdata[0*W +: W];
   assign y1 = req_tdata[1*W +: W];
   assign x2 = req_tdata[2*W +: W];
   assign y2 = req_tdata[3*W +: W];
   assign x3 = req_tdata[4*W +: W];
   assign y3 = req_tdata[5*W +: W];
   assign x4 = req_tdata[6*W +: W];
   assign y4 = req_tdata[7*W +: W];

   // ------------------------------------------------------------------
   // Stage flow control
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   // ------------------------------------------------------------------
   // Stage 1: differences, vertical flags, vertical operand selection
   // ------------------------------------------------------------------
   logic signed [D-1:0] dx1_in, dy1_in, dx2_in, dy2_in, rx_in, ry_in;
   logic signed [D-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, rx_ff, ry_ff;
   logic                va1_in, vb1_in, xeq1_in, va1_ff, vb1_ff, xeq1_ff;
   logic signed [W-1:0] ya_min1_in, ya_max1_in, yb_min1_in, yb_max1_in;
   logic signed [W-1:0] ya_min1_ff, ya_max1_ff, yb_min1_ff, yb_max1_ff;
   logic signed [W-1:0] xv1_in, vylo1_in, vyhi1_in;
   logic signed [W-1:0] xv1_ff, vylo1_ff, vyhi1_ff;
   logic signed [W-1:0] ox3_1_in, oy3_1_in, ox4_1_in, oy4_1_in;
   logic signed [W-1:0] ox3_1_ff, oy3_1_ff, ox4_1_ff, oy4_1_ff;
   logic signed [W-1:0] vya, vyb;

   always_comb begin
      dx1_in = D'(x2) - D'(x1);
      dy1_in = D'(y2) - D'(y1);
      dx2_in = D'(x4) - D'(x3);
      dy2_in = D'(y4) - D'(y3);
      rx_in  = D'(x3) - D'(x1);
      ry_in  = D'(y3) - D'(y1);
      va1_in  = (x1 == x2);
      vb1_in  = (x3 == x4);
      xeq1_in = (x1 == x3);
      ya_min1_in = (y1 < y2) ? y1 : y2;
      ya_max1_in = (y1 > y2) ? y1 : y2;
      yb_min1_in = (y3 < y4) ? y3 : y4;
      yb_max1_in = (y3 > y4) ? y3 : y4;
      // pick the vertical segment and the other one
      if (va1_in) begin
         xv1_in = x1; vya = y1; vyb = y2;
         ox3_1_in = x3; oy3_1_in = y3; ox4_1_in = x4; oy4_1_in = y4;
      end else begin
         xv1_in = x3; vya = y3; vyb = y4;
         ox3_1_in = x1; oy3_1_in = y1; ox4_1_in = x2; oy4_1_in = y2;
      end
      vylo1_in = (vya < vyb) ? vya : vyb;
      vyhi1_in = (vya > vyb) ? vya : vyb;
   end

   // ------------------------------------------------------------------
   // Stage 2: general products, both-vertical test, vertical setup
   // ------------------------------------------------------------------
   logic signed [P-1:0] p1_in, p2_in, p3_in, p4_in, p5_in, p6_in;
   logic signed [P-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic                hvv2_in, vin2_in, hvv2_ff, vin2_ff, va2_ff, vb2_ff;
   logic signed [D-1:0] vd2_in, vlod2_in, vdy2_in, vdx2_in, vhid2_in;
   logic signed [D-1:0] vd2_ff, vlod2_ff, vdy2_ff, vdx2_ff, vhid2_ff;
   logic signed [W-1:0] sx3, sy3, sx4, sy4;

   always_comb begin
      p1_in = P'(dx1_ff) * P'(dy2_ff);
      p2_in = P'(dy1_ff) * P'(dx2_ff);
      p3_in = P'(rx_ff) * P'(dy2_ff);
      p4_in = P'(ry_ff) * P'(dx2_ff);
      p5_in = P'(rx_ff) * P'(dy1_ff);
      p6_in = P'(ry_ff) * P'(dx1_ff);
      hvv2_in = xeq1_ff && !((ya_max1_ff < yb_min1_ff) || (ya_min1_ff > yb_max1_ff));
      // order the other segment by x
      if (ox3_1_ff > ox4_1_ff) begin
         sx3 = ox4_1_ff; sy3 = oy4_1_ff; sx4 = ox3_1_ff; sy4 = oy3_1_ff;
      end else begin
         sx3 = ox3_1_ff; sy3 = oy3_1_ff; sx4 = ox4_1_ff; sy4 = oy4_1_ff;
      end
      vin2_in  = (xv1_ff >= sx3) && (xv1_ff <= sx4);
      vd2_in   = D'(sx4) - D'(sx3);
      vlod2_in = D'(vylo1_ff) - D'(sy3);
      vdy2_in  = D'(sy4) - D'(sy3);
      vdx2_in  = D'(xv1_ff) - D'(sx3);
      vhid2_in = D'(vyhi1_ff) - D'(sy3);
   end

   // ------------------------------------------------------------------
   // Stage 3: cross differences, vertical products
   // ------------------------------------------------------------------
   logic signed [S-1:0] den3_in, tn3_in, sn3_in, den3_ff, tn3_ff, sn3_ff;
   logic signed [P-1:0] vlo3_in, vmid3_in, vhi3_in, vlo3_ff, vmid3_ff, vhi3_ff;
   logic                hvv3_ff, vin3_ff, va3_ff, vb3_ff;

   always_comb begin
      den3_in  = S'(p1_ff) - S'(p2_ff);
      tn3_in   = S'(p3_ff) - S'(p4_ff);
      sn3_in   = S'(p5_ff) - S'(p6_ff);
      vlo3_in  = P'(vlod2_ff) * P'(vd2_ff);
      vmid3_in = P'(vdy2_ff) * P'(vdx2_ff);
      vhi3_in  = P'(vhid2_ff) * P'(vd2_ff);
   end

   // ------------------------------------------------------------------
   // Stage 4: range compares and case select into the output register
   // ------------------------------------------------------------------
   logic hit4_in, hit4_ff;
   logic vhit, gin;

   always_comb begin
      vhit = vin3_ff && (vlo3_ff <= vmid3_ff) && (vmid3_ff <= vhi3_ff);
      if (den3_ff > 0) begin
         gin = (tn3_ff >= 0) && (tn3_ff <= den3_ff) && (sn3_ff >= 0) && (sn3_ff <= den3_ff);
      end else begin
         gin = (tn3_ff <= 0) && (tn3_ff >= den3_ff) && (sn3_ff <= 0) && (sn3_ff >= den3_ff);
      end
      if (va3_ff && vb3_ff) begin
         hit4_in = hvv3_ff;
      end else if (va3_ff || vb3_ff) begin
         hit4_in = vhit;
      end else begin
         hit4_in = (den3_ff != 0) && gin;
      end
   end

   // ------------------------------------------------------------------
   // Valid bits
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage data registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv1) begin
         dx1_ff <= dx1_in; dy1_ff <= dy1_in; dx2_ff <= dx2_in; dy2_ff <= dy2_in;
         rx_ff  <= rx_in;  ry_ff  <= ry_in;
         va1_ff <= va1_in; vb1_ff <= vb1_in; xeq1_ff <= xeq1_in;
         ya_min1_ff <= ya_min1_in; ya_max1_ff <= ya_max1_in;
         yb_min1_ff <= yb_min1_in; yb_max1_ff <= yb_max1_in;
         xv1_ff <= xv1_in; vylo1_ff <= vylo1_in; vyhi1_ff <= vyhi1_in;
         ox3_1_ff <= ox3_1_in; oy3_1_ff <= oy3_1_in;
         ox4_1_ff <= ox4_1_in; oy4_1_ff <= oy4_1_in;
      end
      if (adv2) begin
         p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
         p4_ff <= p4_in; p5_ff <= p5_in; p6_ff <= p6_in;
         hvv2_ff <= hvv2_in; vin2_ff <= vin2_in;
         va2_ff <= va1_ff; vb2_ff <= vb1_ff;
         vd2_ff <= vd2_in; vlod2_ff <= vlod2_in; vdy2_ff <= vdy2_in;
         vdx2_ff <= vdx2_in; vhid2_ff <= vhid2_in;
      end
      if (adv3) begin
         den3_ff <= den3_in; tn3_ff <= tn3_in; sn3_ff <= sn3_in;
         vlo3_ff <= vlo3_in; vmid3_ff <= vmid3_in; vhi3_ff <= vhi3_in;
         hvv3_ff <= hvv2_ff; vin3_ff <= vin2_ff;
         va3_ff <= va2_ff; vb3_ff <= vb2_ff;
      end
      if (adv4) begin
         hit4_ff <= hit4_in;
      end
   end

   // ------------------------------------------------------------------
   // Result stream
   // ------------------------------------------------------------------
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS-1){1'b0}}, hit4_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a full pipeline behind a stalled result takes no new transaction
   `SIT_ASSERT_NOW(a_full_blocks, v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready, !req_tready)
   // an accepted transaction lands in stage 1
   `SIT_ASSERT_NEXT(a_accept_lands, req_tvalid && req_tready, v1_ff)
   // stalled stages 2 to 4 keep their items
   `SIT_ASSERT_NEXT(a_stall_keeps, v2_ff && v3_ff && v4_ff && !rsp_tready, v2_ff && v3_ff && v4_ff)
   // a result leaving with stage 3 full is replaced by that item
   `SIT_ASSERT_NEXT(a_refill, v3_ff && v4_ff && rsp_tready, v4_ff)

endmodule

`default_nettype wire
